[sv/smt_pkg.sv]
package smt_pkg;

	// widths of the stream payloads
	localparam int IN_TDATA_W  = 104;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 112;
	localparam int OUT_TUSER_W = 2;
	localparam int POS_W       = 6;
	localparam int CNT_OUT_W   = 7;

	// one stored descriptor, device id in the lowest bits
	typedef struct packed {
		logic [15:0] logic_id;
		logic [7:0]  local_dyn_id;
		logic [7:0]  sender_dyn_id;
		logic [31:0] msg_counter;
		logic [31:0] dev_id;
	} entry_t;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_READ   = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_FULL    = 2'd1,
		STAT_BAD_POS = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_SCAN,
		S_INS_PUT,
		S_REM_MOVE,
		S_FINISH
	} state_t;

	// what the pending result reports
	typedef enum logic [2:0] {
		KIND_INS,
		KIND_FULL,
		KIND_BAD,
		KIND_POS,
		KIND_READ,
		KIND_NOP
	} kind_t;

	// table read address
	typedef enum logic [2:0] {
		RA_TOP,
		RA_POS,
		RA_POS1,
		RA_DEC,
		RA_INC2
	} rsel_t;

	// table write address and data
	typedef enum logic [1:0] {
		WS_RD_UP,
		WS_NEW_UP,
		WS_NEW_AT,
		WS_RD_AT
	} wsel_t;

	typedef struct packed {
		logic  load;
		logic  rd_en;
		rsel_t rd_sel;
		logic  wr_en;
		wsel_t wr_sel;
		logic  idx_inc;
		logic  idx_dec;
		logic  cnt_inc;
		logic  cnt_dec;
		logic  res_load;
		kind_t kind;
	} smt_ctl_t;

	typedef struct packed {
		cmd_t cmd;
		logic full;
		logic cnt_zero;
		logic pos_bad;
		logic pos_last;
		logic shift;
		logic idx_zero;
		logic rem_done;
		logic res_free;
	} smt_stat_t;

endpackage

[sv/smt_ctrl.sv]
module smt_ctrl import smt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  smt_stat_t stat,
	output smt_ctl_t  ctl
);

	state_t state_q, state_d;
	kind_t  kind_q, kind_d;

	// state and result kind registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= KIND_NOP;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

	// next state and result kind
	always_comb begin
		state_d = state_q;
		kind_d  = kind_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_FINISH;
					unique case (stat.cmd)
						CMD_INSERT: begin
							kind_d = KIND_INS;
							if (stat.full) begin
								kind_d = KIND_FULL;
							end else if (stat.cnt_zero) begin
								state_d = S_INS_PUT;
							end else begin
								state_d = S_INS_SCAN;
							end
						end
						CMD_REMOVE: begin
							kind_d = KIND_POS;
							if (stat.pos_bad) begin
								kind_d = KIND_BAD;
							end else if (!stat.pos_last) begin
								state_d = S_REM_MOVE;
							end
						end
						CMD_READ: begin
							kind_d = stat.pos_bad ? KIND_BAD : KIND_READ;
						end
						CMD_NOP: begin
							kind_d = KIND_NOP;
						end
					endcase
				end
			end
			S_INS_SCAN: begin
				if (!stat.shift) begin
					state_d = S_FINISH;
				end else if (stat.idx_zero) begin
					state_d = S_INS_PUT;
				end
			end
			S_INS_PUT: begin
				state_d = S_FINISH;
			end
			S_REM_MOVE: begin
				if (stat.rem_done) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (stat.res_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// datapath commands
	always_comb begin
		ctl          = '0;
		ctl.rd_sel   = RA_TOP;
		ctl.wr_sel   = WS_RD_UP;
		ctl.kind     = kind_q;
		in_ready     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load = 1'b1;
					unique case (stat.cmd)
						CMD_INSERT: begin
							if (!stat.full && !stat.cnt_zero) begin
								ctl.rd_en  = 1'b1;
								ctl.rd_sel = RA_TOP;
							end
						end
						CMD_REMOVE: begin
							if (!stat.pos_bad && stat.pos_last) begin
								ctl.cnt_dec = 1'b1;
							end else if (!stat.pos_bad) begin
								ctl.rd_en  = 1'b1;
								ctl.rd_sel = RA_POS1;
							end
						end
						CMD_READ: begin
							if (!stat.pos_bad) begin
								ctl.rd_en  = 1'b1;
								ctl.rd_sel = RA_POS;
							end
						end
						CMD_NOP: begin
							ctl.load = 1'b1;
						end
					endcase
				end
			end
			S_INS_SCAN: begin
				ctl.wr_en = 1'b1;
				if (stat.shift) begin
					ctl.wr_sel = WS_RD_UP;
					if (!stat.idx_zero) begin
						ctl.rd_en   = 1'b1;
						ctl.rd_sel  = RA_DEC;
						ctl.idx_dec = 1'b1;
					end
				end else begin
					ctl.wr_sel  = WS_NEW_UP;
					ctl.idx_inc = 1'b1;
					ctl.cnt_inc = 1'b1;
				end
			end
			S_INS_PUT: begin
				ctl.wr_en   = 1'b1;
				ctl.wr_sel  = WS_NEW_AT;
				ctl.cnt_inc = 1'b1;
			end
			S_REM_MOVE: begin
				ctl.wr_en   = 1'b1;
				ctl.wr_sel  = WS_RD_AT;
				ctl.idx_inc = 1'b1;
				if (stat.rem_done) begin
					ctl.cnt_dec = 1'b1;
				end else begin
					ctl.rd_en  = 1'b1;
					ctl.rd_sel = RA_INC2;
				end
			end
			S_FINISH: begin
				ctl.res_load = stat.res_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

[sv/smt_dpath.sv]
module smt_dpath import smt_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [IN_TDATA_W-1:0]  in_data,
	input  logic [IN_TUSER_W-1:0]  in_user,
	input  smt_ctl_t               ctl,
	output smt_stat_t              stat,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [OUT_TDATA_W-1:0] out_data,
	output logic [OUT_TUSER_W-1:0] out_user
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > 7) ? CW : 7;

	entry_t          mem [DEPTH];
	entry_t          rd_q;
	entry_t          new_q;
	logic [POS_W-1:0] pos_q;
	logic [IW-1:0]   idx_q;
	logic [CW-1:0]   count_q;
	logic            out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic [OUT_TUSER_W-1:0] out_user_q;

	entry_t           in_entry;
	logic [POS_W-1:0] in_pos;
	cmd_t             in_cmd;
	logic [XW-1:0]    pos_x;
	logic [XW-1:0]    cnt_x;
	logic [XW-1:0]    idx_x;
	logic [IW-1:0]    top_idx;
	logic [IW-1:0]    rd_addr;
	logic [IW-1:0]    wr_addr;
	entry_t           wr_data;
	status_t          res_status;
	logic [POS_W-1:0] res_where;
	entry_t           res_entry;

	// input field split
	assign in_entry = entry_t'(in_data[95:0]);
	assign in_pos   = in_data[101:96];
	assign in_cmd   = cmd_t'(in_user);

	assign pos_x   = XW'(in_pos);
	assign cnt_x   = XW'(count_q);
	assign idx_x   = XW'(idx_q);
	assign top_idx = (count_q == '0) ? '0 : IW'(count_q - CW'(1));

	// status towards the controller
	always_comb begin
		stat.cmd      = in_cmd;
		stat.full     = (count_q == CW'(DEPTH));
		stat.cnt_zero = (count_q == '0);
		stat.pos_bad  = (pos_x >= cnt_x);
		stat.pos_last = ((pos_x + XW'(1)) == cnt_x);
		stat.shift    = ({rd_q.dev_id, rd_q.msg_counter} >= {new_q.dev_id, new_q.msg_counter});
		stat.idx_zero = (idx_q == '0);
		stat.rem_done = ((idx_x + XW'(2)) == cnt_x);
		stat.res_free = !out_valid_q || out_ready;
	end

	// table addresses and write data
	always_comb begin
		unique case (ctl.rd_sel)
			RA_TOP:  rd_addr = top_idx;
			RA_POS:  rd_addr = IW'(in_pos);
			RA_POS1: rd_addr = IW'(pos_x + XW'(1));
			RA_DEC:  rd_addr = idx_q - IW'(1);
			RA_INC2: rd_addr = IW'(idx_x + XW'(2));
			default: rd_addr = '0;
		endcase
		unique case (ctl.wr_sel)
			WS_RD_UP: begin
				wr_addr = idx_q + IW'(1);
				wr_data = rd_q;
			end
			WS_NEW_UP: begin
				wr_addr = idx_q + IW'(1);
				wr_data = new_q;
			end
			WS_NEW_AT: begin
				wr_addr = idx_q;
				wr_data = new_q;
			end
			WS_RD_AT: begin
				wr_addr = idx_q;
				wr_data = rd_q;
			end
			default: begin
				wr_addr = idx_q;
				wr_data = rd_q;
			end
		endcase
	end

	// descriptor table, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// command operands and scan index
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			new_q <= in_entry;
			pos_q <= in_pos;
		end
		if (ctl.load) begin
			idx_q <= (in_cmd == CMD_INSERT) ? top_idx : IW'(in_pos);
		end else if (ctl.idx_inc) begin
			idx_q <= idx_q + IW'(1);
		end else if (ctl.idx_dec) begin
			idx_q <= idx_q - IW'(1);
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.cnt_inc) begin
			count_q <= count_q + CW'(1);
		end else if (ctl.cnt_dec) begin
			count_q <= count_q - CW'(1);
		end
	end

	// result fields by kind
	always_comb begin
		res_status = STAT_OK;
		res_where  = '0;
		res_entry  = '0;
		unique case (ctl.kind)
			KIND_INS:  res_where = POS_W'(idx_q);
			KIND_FULL: res_status = STAT_FULL;
			KIND_BAD: begin
				res_status = STAT_BAD_POS;
				res_where  = pos_q;
			end
			KIND_POS:  res_where = pos_q;
			KIND_READ: begin
				res_where = pos_q;
				res_entry = rd_q;
			end
			KIND_NOP:  res_where = '0;
			default:   res_where = '0;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.res_load) begin
			out_data_q <= {3'b000, res_entry, CNT_OUT_W'(count_q), res_where};
			out_user_q <= res_status;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_user  = out_user_q;

endmodule

[sv/sorted_message_table_unit.sv]
// Sorted message table: keeps up to DEPTH descriptors in ascending order of
// device id, then message counter, in a table memory (one write and one
// registered read per cycle). One command is worked at a time. A read, a
// command refused as full or out of range, an unused command and a remove
// of the last entry go from idle straight to the finish state, which loads
// the result register. An insert shifts the entries not below the new one
// up from the top, then writes it; a remove at p shifts those above p down;
// each moves one entry per cycle through the table memory. A new command is
// taken while the previous result still waits in the output register; the
// last cycle of a command is held until that result has gone. Positions are
// 6 bits wide, so with DEPTH above 64 only the first 64 places can be named
// and where reports the low bits only, as does entry_count with DEPTH above 127.
module sorted_message_table_unit import smt_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// dev_id, msg_counter, sender_dyn_id, local_dyn_id, logic_id, position, zero pad
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// cmd
	input  logic [IN_TUSER_W-1:0]  s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// where, entry_count, out_dev_id, out_counter, out_sender_dyn_id,
	// out_local_dyn_id, out_logic_id, zero pad
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// status
	output logic [OUT_TUSER_W-1:0] m_tuser
);

	smt_ctl_t  ctl;
	smt_stat_t stat;

	// command sequencer
	smt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.ctl      (ctl)
	);

	// table, operands and result register
	smt_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_tdata),
		.in_user   (s_tuser),
		.ctl       (ctl),
		.stat      (stat),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_user  (m_tuser)
	);

	// a pending result is never overwritten
	a_res_free : assert property (@(posedge clk) disable iff (!arst_n)
		ctl.res_load |-> stat.res_free)
		else $error("result loaded over a pending beat");

	// an insert never grows a full table
	a_no_overfill : assert property (@(posedge clk) disable iff (!arst_n)
		ctl.cnt_inc |-> !stat.full)
		else $error("entry count grown past depth");

	// the table is only written while a command is being worked
	a_wr_busy : assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_en |-> !s_tready)
		else $error("table written while idle");

	// no second command is taken in the cycle after an accepted one
	a_one_result : assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("command taken while another is in work");

endmodule
